// ===== src/lavm_pkg.sv =====
// Shared types, constants and fixed-point helpers for the look-at view matrix pipeline.
package lavm_pkg;

	localparam int WORD_W = 32;
	localparam int WIDE_W = 67;
	localparam int ISQ_STEPS = 32;
	// Abs/max, shift, square and sum stages, the root steps and the divider setup stage.
	localparam int NORM_BASE_LAT = 4 + ISQ_STEPS + 1;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [WIDE_W-1:0] wide_t;
	typedef logic signed [63:0] prod_t;

	typedef struct packed {
		logic       zero;
		logic [2:0] neg;
	} norm_flags_t;

	// Round to nearest with ties toward plus infinity, dropping f fraction bits.
	function automatic wide_t round_frac(input wide_t x, input int f);
		wide_t half;
		half = wide_t'(1) <<< (f - 1);
		return (x + half) >>> f;
	endfunction

	function automatic word_t sat_word(input wide_t x);
		wide_t hi;
		wide_t lo;
		hi = wide_t'(64'sd2147483647);
		lo = -wide_t'(64'sd2147483648);
		if (x > hi) begin
			return word_t'(32'h7fffffff);
		end else if (x < lo) begin
			return word_t'(32'h80000000);
		end else begin
			return x[WORD_W-1:0];
		end
	endfunction

endpackage

// ===== src/look_at_view_matrix.sv =====
// Top level of the look-at view matrix pipeline.
//
// This block turns a camera look direction, up hint and position (signed fixed point with
// FRACTION_BITS fraction bits) into the rotation rows right, orthogonalized up and back,
// plus the translation of a view matrix. It is fully pipelined and takes a new request in
// every cycle unless the output side stalls. Most of the pipeline lies in the normalizer: a
// square root that resolves one bit per stage over 32 stages, then a long division that
// resolves one quotient bit per stage over FRACTION_BITS + 1 stages; after it come two
// cross products and the dot products with the position. The whole pipeline advances
// together whenever the output register is empty or being taken, so a stall on the output
// side holds every request in place and nothing is lost or repeated. A zero look or up
// vector gives an all-zero result; parallel look and up give zero right and up rows. The
// right, up and translation outputs are rounded to nearest and saturated to the signed
// 32-bit range.
module look_at_view_matrix import lavm_pkg::*; #(
	parameter int FRACTION_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// Fields from bit 0 up: look_x, look_y, look_z, up_x, up_y, up_z, pos_x, pos_y, pos_z.
	input  logic [287:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// Fields from bit 0 up: right_x, right_y, right_z, upv_x, upv_y, upv_z,
	// back_x, back_y, back_z, trans_x, trans_y, trans_z.
	output logic [383:0] m_axis_tdata
);

	localparam int F = FRACTION_BITS;
	localparam int NORM_LAT = NORM_BASE_LAT + F + 1;

	// The pipeline moves as one; it only waits when a finished result is not taken.
	logic adv;
	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	word_t look_in [3];
	word_t up_in   [3];
	word_t pos_in  [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			look_in[i] = s_axis_tdata[32*i +: 32];
			up_in[i]   = s_axis_tdata[96 + 32*i +: 32];
			pos_in[i]  = s_axis_tdata[192 + 32*i +: 32];
		end
	end

	// Both vectors are normalized side by side in identical pipelines.
	logic           lv_n;
	logic           uv_n;
	logic [F:0]     lq_n [3];
	logic [F:0]     uq_n [3];
	norm_flags_t    lfl_n;
	norm_flags_t    ufl_n;

	lavm_norm #(.FRACTION_BITS(F)) u_norm_look (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (s_axis_tvalid),
		.vec       (look_in),
		.out_valid (lv_n),
		.out_q     (lq_n),
		.out_flags (lfl_n)
	);

	lavm_norm #(.FRACTION_BITS(F)) u_norm_up (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (s_axis_tvalid),
		.vec       (up_in),
		.out_valid (uv_n),
		.out_q     (uq_n),
		.out_flags (ufl_n)
	);

	// The position waits alongside the normalizer in a plain delay line.
	word_t pos_d [NORM_LAT+1][3];
	assign pos_d[0] = pos_in;

	for (genvar d = 0; d < NORM_LAT; d++) begin : g_pos
		always_ff @(posedge clk) begin
			if (adv) begin
				pos_d[d+1] <= pos_d[d];
			end
		end
	end

	// Stage 1: apply the signs to the normalized components.
	logic  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic  z_s1, z_s2, z_s3, z_s4, z_s5, z_s6;
	word_t ln_s1 [3];
	word_t un_s1 [3];
	word_t pos_s1 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				ln_s1[i] <= lfl_n.neg[i] ? -word_t'(32'(lq_n[i])) : word_t'(32'(lq_n[i]));
				un_s1[i] <= ufl_n.neg[i] ? -word_t'(32'(uq_n[i])) : word_t'(32'(uq_n[i]));
			end
			pos_s1 <= pos_d[NORM_LAT];
			z_s1   <= lfl_n.zero || ufl_n.zero;
		end
	end

	// Stage 2: products for right = look x up.
	prod_t pa_s2 [3];
	prod_t pb_s2 [3];
	word_t ln_s2 [3];
	word_t pos_s2 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			pa_s2[0] <= prod_t'(ln_s1[1]) * prod_t'(un_s1[2]);
			pb_s2[0] <= prod_t'(ln_s1[2]) * prod_t'(un_s1[1]);
			pa_s2[1] <= prod_t'(ln_s1[2]) * prod_t'(un_s1[0]);
			pb_s2[1] <= prod_t'(ln_s1[0]) * prod_t'(un_s1[2]);
			pa_s2[2] <= prod_t'(ln_s1[0]) * prod_t'(un_s1[1]);
			pb_s2[2] <= prod_t'(ln_s1[1]) * prod_t'(un_s1[0]);
			ln_s2  <= ln_s1;
			pos_s2 <= pos_s1;
			z_s2   <= z_s1;
		end
	end

	// Stage 3: round and saturate right.
	word_t rt_s3 [3];
	word_t ln_s3 [3];
	word_t pos_s3 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				rt_s3[i] <= sat_word(round_frac(wide_t'(pa_s2[i]) - wide_t'(pb_s2[i]), F));
			end
			ln_s3  <= ln_s2;
			pos_s3 <= pos_s2;
			z_s3   <= z_s2;
		end
	end

	// Stage 4: products for up = right x look, and for the right and look dot products.
	prod_t qa_s4 [3];
	prod_t qb_s4 [3];
	prod_t dr_s4 [3];
	prod_t dl_s4 [3];
	word_t rt_s4 [3];
	word_t ln_s4 [3];
	word_t pos_s4 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			qa_s4[0] <= prod_t'(rt_s3[1]) * prod_t'(ln_s3[2]);
			qb_s4[0] <= prod_t'(rt_s3[2]) * prod_t'(ln_s3[1]);
			qa_s4[1] <= prod_t'(rt_s3[2]) * prod_t'(ln_s3[0]);
			qb_s4[1] <= prod_t'(rt_s3[0]) * prod_t'(ln_s3[2]);
			qa_s4[2] <= prod_t'(rt_s3[0]) * prod_t'(ln_s3[1]);
			qb_s4[2] <= prod_t'(rt_s3[1]) * prod_t'(ln_s3[0]);
			for (int i = 0; i < 3; i++) begin
				dr_s4[i] <= prod_t'(rt_s3[i]) * prod_t'(pos_s3[i]);
				dl_s4[i] <= prod_t'(ln_s3[i]) * prod_t'(pos_s3[i]);
			end
			rt_s4  <= rt_s3;
			ln_s4  <= ln_s3;
			pos_s4 <= pos_s3;
			z_s4   <= z_s3;
		end
	end

	// Stage 5: round up, finish the right and look translations, negate look.
	word_t uv_s5 [3];
	word_t rt_s5 [3];
	word_t bk_s5 [3];
	word_t tx_s5;
	word_t tz_s5;
	word_t pos_s5 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				uv_s5[i] <= sat_word(round_frac(wide_t'(qa_s4[i]) - wide_t'(qb_s4[i]), F));
				bk_s5[i] <= -ln_s4[i];
			end
			tx_s5 <= sat_word(-round_frac(wide_t'(dr_s4[0]) + wide_t'(dr_s4[1])
				+ wide_t'(dr_s4[2]), F));
			tz_s5 <= sat_word(round_frac(wide_t'(dl_s4[0]) + wide_t'(dl_s4[1])
				+ wide_t'(dl_s4[2]), F));
			rt_s5  <= rt_s4;
			pos_s5 <= pos_s4;
			z_s5   <= z_s4;
		end
	end

	// Stage 6: products for the up translation.
	prod_t du_s6 [3];
	word_t uv_s6 [3];
	word_t rt_s6 [3];
	word_t bk_s6 [3];
	word_t tx_s6;
	word_t tz_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				du_s6[i] <= prod_t'(uv_s5[i]) * prod_t'(pos_s5[i]);
			end
			uv_s6 <= uv_s5;
			rt_s6 <= rt_s5;
			bk_s6 <= bk_s5;
			tx_s6 <= tx_s5;
			tz_s6 <= tz_s5;
			z_s6  <= z_s5;
		end
	end

	// Stage 7: output register; a degenerate request gives all zeros.
	word_t ty_c;
	assign ty_c = sat_word(-round_frac(wide_t'(du_s6[0]) + wide_t'(du_s6[1])
		+ wide_t'(du_s6[2]), F));

	always_ff @(posedge clk) begin
		if (adv) begin
			if (z_s6) begin
				m_axis_tdata <= '0;
			end else begin
				m_axis_tdata <= {tz_s6, ty_c, tx_s6,
					bk_s6[2], bk_s6[1], bk_s6[0],
					uv_s6[2], uv_s6[1], uv_s6[0],
					rt_s6[2], rt_s6[1], rt_s6[0]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= lv_n && uv_n;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	assign m_axis_tvalid = v_s7;

endmodule

// ===== src/lavm_norm.sv =====
// Pipelined vector normalizer: scaling, squares, bit-per-stage square root and long division.
module lavm_norm import lavm_pkg::*; #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  word_t                    vec [3],
	output logic                     out_valid,
	output logic [FRACTION_BITS:0]   out_q [3],
	output norm_flags_t              out_flags
);

	localparam int F  = FRACTION_BITS;
	localparam int NW = WORD_W + F;
	localparam int QW = F + 1;

	// Stage 1: magnitudes and the largest of them.
	logic [31:0] abs_c [3];
	logic [31:0] mx_c;
	logic        v_s1;
	logic [31:0] m_s1 [3];
	logic [31:0] mx_s1;
	logic [2:0]  neg_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			abs_c[i] = vec[i][31] ? 32'(-vec[i]) : 32'(vec[i]);
		end
		mx_c = abs_c[0];
		if (abs_c[1] > mx_c) begin
			mx_c = abs_c[1];
		end
		if (abs_c[2] > mx_c) begin
			mx_c = abs_c[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1   <= abs_c;
			mx_s1  <= mx_c;
			neg_s1 <= {vec[2][31], vec[1][31], vec[0][31]};
		end
	end

	// Stage 2: shift left until the largest magnitude reaches 2^30, in binary steps.
	logic [31:0] sh_m [3];
	logic [31:0] sh_mx;
	logic        v_s2;
	logic [31:0] m_s2 [3];
	norm_flags_t fl_s2;

	always_comb begin
		int k;
		sh_m  = m_s1;
		sh_mx = mx_s1;
		for (int s = 0; s < 5; s++) begin
			k = 16 >> s;
			if (sh_mx < (32'd1 << (31 - k))) begin
				sh_mx = sh_mx << k;
				for (int i = 0; i < 3; i++) begin
					sh_m[i] = sh_m[i] << k;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s2       <= sh_m;
			fl_s2.zero <= (mx_s1 == 32'd0);
			fl_s2.neg  <= neg_s1;
		end
	end

	// Stage 3: squares.
	logic        v_s3;
	logic [63:0] sq_s3 [3];
	logic [31:0] m_s3 [3];
	norm_flags_t fl_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s3[i] <= 64'(m_s2[i]) * 64'(m_s2[i]);
			end
			m_s3  <= m_s2;
			fl_s3 <= fl_s2;
		end
	end

	// Stage 4: sum of squares feeds the root pipeline at index zero.
	logic        rv   [ISQ_STEPS+1];
	logic [63:0] rnum [ISQ_STEPS+1];
	logic [63:0] rres [ISQ_STEPS+1];
	logic [31:0] rm   [ISQ_STEPS+1][3];
	norm_flags_t rfl  [ISQ_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv[0] <= 1'b0;
		end else if (en) begin
			rv[0] <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rnum[0] <= sq_s3[0] + sq_s3[1] + sq_s3[2];
			rres[0] <= 64'd0;
			rm[0]   <= m_s3;
			rfl[0]  <= fl_s3;
		end
	end

	// Integer square root, one result bit per stage.
	for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_isq
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
		logic [63:0] trial;
		assign trial = rres[k] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rv[k+1] <= 1'b0;
			end else if (en) begin
				rv[k+1] <= rv[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rnum[k] >= trial) begin
					rnum[k+1] <= rnum[k] - trial;
					rres[k+1] <= (rres[k] >> 1) + BIT;
				end else begin
					rnum[k+1] <= rnum[k];
					rres[k+1] <= rres[k] >> 1;
				end
				rm[k+1]  <= rm[k];
				rfl[k+1] <= rfl[k];
			end
		end
	end

	// Divider setup: numerator is the scaled magnitude plus half the length.
	logic          dv   [QW+1];
	logic [31:0]   dlen [QW+1];
	logic [NW-1:0] drem [QW+1][3];
	logic [QW-1:0] dq   [QW+1][3];
	norm_flags_t   dfl  [QW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv[0] <= 1'b0;
		end else if (en) begin
			dv[0] <= rv[ISQ_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dlen[0] <= rres[ISQ_STEPS][31:0];
			for (int i = 0; i < 3; i++) begin
				drem[0][i] <= (NW'(rm[ISQ_STEPS][i]) << F)
					+ NW'(rres[ISQ_STEPS][31:1]);
				dq[0][i] <= '0;
			end
			dfl[0] <= rfl[ISQ_STEPS];
		end
	end

	// Restoring division, one quotient bit per stage from the top bit down.
	for (genvar j = 0; j < QW; j++) begin : g_div
		logic [NW-1:0] dsor;
		assign dsor = NW'(dlen[j]) << (F - j);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv[j+1] <= 1'b0;
			end else if (en) begin
				dv[j+1] <= dv[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					if (drem[j][i] >= dsor) begin
						drem[j+1][i] <= drem[j][i] - dsor;
						dq[j+1][i]   <= dq[j][i] | (QW'(1) << (F - j));
					end else begin
						drem[j+1][i] <= drem[j][i];
						dq[j+1][i]   <= dq[j][i];
					end
				end
				dlen[j+1] <= dlen[j];
				dfl[j+1]  <= dfl[j];
			end
		end
	end

	assign out_valid = dv[QW];
	assign out_q     = dq[QW];
	assign out_flags = dfl[QW];

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the look-at view matrix pipeline.
`timescale 1ns / 100ps

module testbench import lavm_pkg::*; ();

	localparam int FRAC = 16;
	localparam int LATENCY = 45 + FRAC;
	localparam int WATCHDOG_LIMIT = 20000;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [287:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [383:0] m_axis_tdata;

	int send_idle_pct;
	int recv_stall_pct;
	int fail_count;
	int quiet_cycles;
	logic [383:0] view_queue[$];

	look_at_view_matrix #(.FRACTION_BITS(FRAC)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Signed value divided by 2^s, rounded toward minus infinity.
	function automatic longint floor_div(input longint x, input int s);
		return x >>> s;
	endfunction

	function automatic longint round_fix(input longint x);
		return (x + (longint'(1) << (FRAC - 1))) >>> FRAC;
	endfunction

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end else if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned num);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > num) bitv >>= 2;
		while (bitv != 0) begin
			if (num >= res + bitv) begin
				num -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// Returns 0 for a zero-length vector.
	function automatic bit unit_vector(input longint v[3], output longint n[3]);
		longint unsigned m[3];
		longint unsigned peak;
		longint unsigned sum;
		longint unsigned len;
		longint unsigned q;
		peak = 0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
			if (m[i] > peak) peak = m[i];
			n[i] = 0;
		end
		if (peak == 0) return 1'b0;
		while (peak < (64'd1 << 30)) begin
			peak <<= 1;
			for (int i = 0; i < 3; i++) m[i] <<= 1;
		end
		for (int i = 0; i < 3; i++) sum += m[i] * m[i];
		len = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << FRAC) + (len >> 1)) / len;
			n[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
		end
		return 1'b1;
	endfunction

	function automatic void cross_fix(input longint a[3], input longint b[3],
			output longint r[3]);
		r[0] = clamp32(round_fix(a[1] * b[2] - a[2] * b[1]));
		r[1] = clamp32(round_fix(a[2] * b[0] - a[0] * b[2]));
		r[2] = clamp32(round_fix(a[0] * b[1] - a[1] * b[0]));
	endfunction

	// The three products can overflow 64 bits together, so whole and fraction parts are summed apart.
	function automatic longint dot_fix(input longint a[3], input longint b[3]);
		longint hi;
		longint lo;
		longint p;
		longint h;
		hi = 0;
		lo = 0;
		for (int i = 0; i < 3; i++) begin
			p = a[i] * b[i];
			h = floor_div(p, FRAC);
			hi += h;
			lo += p - (h <<< FRAC);
		end
		return hi + round_fix(lo);
	endfunction

	function automatic logic [383:0] predict_view(input logic [287:0] req);
		longint look[3], upv[3], pos[3], ln[3], un[3], rt[3], uo[3];
		longint res[12];
		logic [383:0] packed_res;
		for (int i = 0; i < 3; i++) begin
			look[i] = longint'(word_t'(req[32*i +: 32]));
			upv[i] = longint'(word_t'(req[32*(3+i) +: 32]));
			pos[i] = longint'(word_t'(req[32*(6+i) +: 32]));
		end
		for (int i = 0; i < 12; i++) res[i] = 0;
		if (unit_vector(look, ln) && unit_vector(upv, un)) begin
			cross_fix(ln, un, rt);
			cross_fix(rt, ln, uo);
			for (int i = 0; i < 3; i++) begin
				res[i] = rt[i];
				res[3+i] = uo[i];
				res[6+i] = clamp32(-ln[i]);
			end
			res[9] = clamp32(-dot_fix(rt, pos));
			res[10] = clamp32(-dot_fix(uo, pos));
			res[11] = clamp32(dot_fix(ln, pos));
		end
		for (int i = 0; i < 12; i++) packed_res[32*i +: 32] = res[i][31:0];
		return packed_res;
	endfunction

	function automatic string field_name(input int idx);
		case (idx)
			0: return "right_x";
			1: return "right_y";
			2: return "right_z";
			3: return "upv_x";
			4: return "upv_y";
			5: return "upv_z";
			6: return "back_x";
			7: return "back_y";
			8: return "back_z";
			9: return "trans_x";
			10: return "trans_y";
			default: return "trans_z";
		endcase
	endfunction

	// Drives one request at the falling edge and holds it until it is taken.
	// Valid stays high after the handshake so that requests can follow back to back.
	task automatic send_request(input logic [287:0] req);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= req;
		view_queue.push_back(predict_view(req));
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'h80000000;
			1: return 32'h7fffffff;
			2: return $urandom_range(2 * 65536) - 65536;
			3: return $urandom_range(255) - 128;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [287:0] pack_req(input logic [31:0] w[9]);
		logic [287:0] r;
		for (int i = 0; i < 9; i++) r[32*i +: 32] = w[i];
		return r;
	endfunction

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (view_queue.size() != 0) @(negedge clk);
	endtask

	task automatic test_directed();
		logic [31:0] w[9];
		logic [31:0] corner[6] = '{32'h80000000, 32'h7fffffff, 32'h0, 32'h1,
			32'hffffffff, 32'h00010000};
		// Zero look, zero up, parallel and antiparallel look and up.
		w = '{0, 0, 0, 32'h10000, 0, 0, 5, 6, 7};
		send_request(pack_req(w));
		w = '{32'h10000, 0, 0, 0, 0, 0, 5, 6, 7};
		send_request(pack_req(w));
		w = '{0, 0, 32'h20000, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff};
		send_request(pack_req(w));
		w = '{32'h10000, 32'h10000, 0, 32'hfffe0000, 32'hfffe0000, 0, 1, 2, 3};
		send_request(pack_req(w));
		w = '{0, 0, 32'hffff0000, 0, 32'h10000, 0, 32'h30000, 32'h40000, 32'h50000};
		send_request(pack_req(w));
		// Extreme positions drive the translation into saturation.
		w = '{32'h10000, 32'h10000, 32'h10000, 0, 32'h10000, 0,
			32'h80000000, 32'h80000000, 32'h80000000};
		send_request(pack_req(w));
		w = '{32'hffff0000, 32'hffff0000, 32'hffff0000, 32'h1, 0, 0,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
		send_request(pack_req(w));
		for (int k = 0; k < 12; k++) begin
			for (int i = 0; i < 9; i++) w[i] = corner[(k + i * (k + 1)) % 6];
			send_request(pack_req(w));
		end
	endtask

	task automatic test_random(input int count);
		logic [31:0] w[9];
		for (int k = 0; k < count; k++) begin
			for (int i = 0; i < 9; i++) w[i] = rand_word();
			send_request(pack_req(w));
		end
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Checks every accepted result against the oldest prediction.
	always @(posedge clk) begin
		logic [383:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (view_queue.size() == 0) begin
				$error("result with no request outstanding");
				fail_count++;
			end else begin
				want = view_queue.pop_front();
				for (int i = 0; i < 12; i++) begin
					if (want[32*i +: 32] !== m_axis_tdata[32*i +: 32]) begin
						$error("%s: expected %0d, got %0d", field_name(i),
							$signed(want[32*i +: 32]), $signed(m_axis_tdata[32*i +: 32]));
						fail_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| !arst_n) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		fail_count = 0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b1;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		set_idling(0, 0);
		test_directed();
		test_random(160);
		// Hold the sender until the pipeline has emptied.
		wait_drained();
		set_idling(71, 0);
		test_random(160);
		set_idling(0, 71);
		test_random(160);
		set_idling(32, 32);
		test_random(160);
		wait_drained();
		repeat (LATENCY + 10) @(negedge clk);
		if (fail_count == 0 && view_queue.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
